FILE: src/lwp_pkg.sv
// Shared constants, types and helpers for the latency window percentile block.
`timescale 1ns / 1ps
package lwp_pkg;

  localparam int DEPTH    = 2048;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = AW + 1;
  localparam int VW       = 31;
  localparam int BW       = $clog2(VW);
  localparam int QW       = 16;

  localparam logic [QW-1:0] Q_P50 = 16'd32768;
  localparam logic [QW-1:0] Q_P95 = 16'd62259;
  localparam logic [QW-1:0] Q_P99 = 16'd64881;

  localparam logic [1:0] FUNC_STORE  = 2'd0;
  localparam logic [1:0] FUNC_REPORT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] SEL_P50 = 2'd0;
  localparam logic [1:0] SEL_P95 = 2'd1;
  localparam logic [1:0] SEL_P99 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_SCAN,
    ST_DECIDE,
    ST_NEXT,
    ST_MUL,
    ST_FINISH,
    ST_DONE
  } state_t;

  // Q0.16 fraction for each reported percentile
  function automatic logic [QW-1:0] q_of(input logic [1:0] sel);
    logic [QW-1:0] q;
    case (sel)
      SEL_P50: q = Q_P50;
      SEL_P95: q = Q_P95;
      SEL_P99: q = Q_P99;
      default: q = Q_P50;
    endcase
    return q;
  endfunction

endpackage

FILE: src/latency_window_percentile_core.sv
// Top level: windowed latency store with radix-select percentile report.
`timescale 1ns / 1ps
// Channel   Direction  Signals                                   Handshake
// request   in         func, sample_value                        start & !busy
// result    out        median_latency, p95_latency, p99_latency, done strobe, 1 cycle
//                      sample_count
//
// Busy stays low for store and clear requests.
// A report finds each order statistic by a bitwise radix select: 31 passes
// per rank over the held samples through the single store read port, two
// ranks per percentile. busy stays high through the report, done included;
// an empty window goes straight to done.
// rst is synchronous; the store contents are not cleared, only count/pointer.
// The receiver cannot stall: done marks the result for exactly one cycle.
module latency_window_percentile_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func,
  input  logic signed [31:0]          sample_value,
  output logic                        done,
  output logic [lwp_pkg::VW-1:0]      median_latency,
  output logic [lwp_pkg::VW-1:0]      p95_latency,
  output logic [lwp_pkg::VW-1:0]      p99_latency,
  output logic [lwp_pkg::CW-1:0]      sample_count
);

  lwp_pkg::state_t state, state_next;

  logic [lwp_pkg::VW-1:0] mem [lwp_pkg::DEPTH];
  logic [lwp_pkg::VW-1:0] rd_data;
  logic                   rd_valid;
  logic                   rd_issue;

  logic [lwp_pkg::AW-1:0] write_pointer;
  logic [lwp_pkg::CW-1:0] held_count;

  logic [1:0]             sel;
  logic                   which;
  logic [lwp_pkg::BW-1:0] bitpos;
  logic [lwp_pkg::AW-1:0] kval;
  logic [lwp_pkg::VW-1:0] prefix;
  logic [lwp_pkg::CW-1:0] cnt;
  logic [lwp_pkg::CW-1:0] idx;
  logic [lwp_pkg::QW-1:0] frac;
  logic [lwp_pkg::VW-1:0] lo_val;
  logic [lwp_pkg::VW-1:0] hi_val;
  logic [lwp_pkg::VW+lwp_pkg::QW-1:0] prod;

  logic                   accept;
  logic                   scan_end;
  logic                   last_bit;
  logic [lwp_pkg::VW-1:0] bit_mask;
  logic [lwp_pkg::VW-1:0] hi_mask;
  logic                   match;
  logic [lwp_pkg::AW+lwp_pkg::QW-1:0] pos;
  logic [lwp_pkg::AW-1:0] lo_idx;
  logic [lwp_pkg::CW-1:0] lo_inc;
  logic [lwp_pkg::AW-1:0] hi_idx;

  assign accept   = start && (state == lwp_pkg::ST_IDLE);
  assign scan_end = (idx == held_count) && !rd_valid;
  assign last_bit = (bitpos == '0);

  // bits at and above the current position take part in the compare
  assign bit_mask = lwp_pkg::VW'(1) << bitpos;
  assign hi_mask  = ~(bit_mask - lwp_pkg::VW'(1));
  assign match    = (((rd_data ^ prefix) & hi_mask) == '0);

  // rank position q * (count - 1)
  assign pos    = lwp_pkg::q_of(sel) * lwp_pkg::AW'(held_count - lwp_pkg::CW'(1));
  assign lo_idx = pos[lwp_pkg::AW+lwp_pkg::QW-1:lwp_pkg::QW];
  assign lo_inc = {1'b0, lo_idx} + lwp_pkg::CW'(1);
  assign hi_idx = (lo_inc < held_count) ? lo_inc[lwp_pkg::AW-1:0] : lo_idx;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lwp_pkg::ST_IDLE: begin
        if (accept && func == lwp_pkg::FUNC_REPORT) begin
          state_next = (held_count == '0) ? lwp_pkg::ST_DONE : lwp_pkg::ST_RANK;
        end
      end
      lwp_pkg::ST_RANK:   state_next = lwp_pkg::ST_SCAN;
      lwp_pkg::ST_SCAN:   if (scan_end) state_next = lwp_pkg::ST_DECIDE;
      lwp_pkg::ST_DECIDE: state_next = last_bit ? lwp_pkg::ST_NEXT : lwp_pkg::ST_SCAN;
      lwp_pkg::ST_NEXT:   state_next = which ? lwp_pkg::ST_MUL : lwp_pkg::ST_RANK;
      lwp_pkg::ST_MUL:    state_next = lwp_pkg::ST_FINISH;
      lwp_pkg::ST_FINISH: begin
        state_next = (sel == lwp_pkg::SEL_P99) ? lwp_pkg::ST_DONE : lwp_pkg::ST_RANK;
      end
      lwp_pkg::ST_DONE:   state_next = lwp_pkg::ST_IDLE;
      default:            state_next = lwp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy     = (state != lwp_pkg::ST_IDLE);
    done     = (state == lwp_pkg::ST_DONE);
    rd_issue = (state == lwp_pkg::ST_SCAN) && (idx != held_count);
  end

  // sample store, one write and one registered read
  always_ff @(posedge clk) begin
    if (accept && func == lwp_pkg::FUNC_STORE && !sample_value[31]) begin
      mem[write_pointer] <= sample_value[lwp_pkg::VW-1:0];
    end
    rd_data <= mem[idx[lwp_pkg::AW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lwp_pkg::ST_IDLE;
      write_pointer <= '0;
      held_count    <= '0;
      rd_valid      <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_issue;
      if (accept && func == lwp_pkg::FUNC_STORE && !sample_value[31]) begin
        write_pointer <= write_pointer + lwp_pkg::AW'(1);
        if (held_count != lwp_pkg::CW'(lwp_pkg::DEPTH)) begin
          held_count <= held_count + lwp_pkg::CW'(1);
        end
      end else if (accept && func == lwp_pkg::FUNC_CLEAR) begin
        write_pointer <= '0;
        held_count    <= '0;
      end
    end
  end

  // select datapath
  always_ff @(posedge clk) begin
    if (rd_valid && match && !rd_data[bitpos]) begin
      cnt <= cnt + lwp_pkg::CW'(1);
    end
    if (rd_issue) begin
      idx <= idx + lwp_pkg::CW'(1);
    end
    case (state)
      lwp_pkg::ST_IDLE: begin
        sel            <= lwp_pkg::SEL_P50;
        which          <= 1'b0;
        median_latency <= '0;
        p95_latency    <= '0;
        p99_latency    <= '0;
        sample_count   <= held_count;
      end
      lwp_pkg::ST_RANK: begin
        frac   <= pos[lwp_pkg::QW-1:0];
        kval   <= which ? hi_idx : lo_idx;
        prefix <= '0;
        bitpos <= lwp_pkg::BW'(lwp_pkg::VW - 1);
        idx    <= '0;
        cnt    <= '0;
      end
      lwp_pkg::ST_DECIDE: begin
        // fewer than k+1 zeros here: the rank lies in the ones half
        if ({1'b0, kval} >= cnt) begin
          prefix <= prefix | bit_mask;
          kval   <= kval - cnt[lwp_pkg::AW-1:0];
        end
        if (!last_bit) begin
          bitpos <= bitpos - lwp_pkg::BW'(1);
        end
        idx <= '0;
        cnt <= '0;
      end
      lwp_pkg::ST_NEXT: begin
        if (which) begin
          hi_val <= prefix;
        end else begin
          lo_val <= prefix;
        end
        which <= ~which;
      end
      lwp_pkg::ST_MUL: begin
        prod <= (hi_val - lo_val) * frac;
      end
      lwp_pkg::ST_FINISH: begin
        case (sel)
          lwp_pkg::SEL_P50: median_latency <= lo_val + prod[lwp_pkg::VW+lwp_pkg::QW-1:lwp_pkg::QW];
          lwp_pkg::SEL_P95: p95_latency    <= lo_val + prod[lwp_pkg::VW+lwp_pkg::QW-1:lwp_pkg::QW];
          default:          p99_latency    <= lo_val + prod[lwp_pkg::VW+lwp_pkg::QW-1:lwp_pkg::QW];
        endcase
        sel <= sel + 2'd1;
      end
      default: begin
      end
    endcase
  end

endmodule
